FILE: sv/sed_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sed_pkg;

  localparam int unsigned AngleW  = 8;
  localparam int unsigned DistW   = 11;
  localparam int unsigned CountW  = 4;
  localparam int unsigned NumberW = 8;
  localparam int unsigned MiddleW = 9;
  localparam int unsigned ProdW   = 15;

  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 40;

  localparam logic [CountW-1:0]  CountMax      = 4'd15;
  localparam logic [CountW-1:0]  MinDetReset   = 4'd2;
  localparam logic [NumberW-1:0] NumberMax     = 8'd255;
  localparam logic [9:0]         MiddleOffset  = 10'sd2;
  localparam logic [9:0]         MiddleMax     = 10'sd255;

  typedef struct packed {
    logic                  start_of_sweep;
    logic [AngleW-1:0]     angle;
    logic [DistW-1:0]      ir_distance;
  } item_t;

  typedef struct packed {
    logic [NumberW-1:0]        object_number;
    logic [AngleW-1:0]         object_start_angle;
    logic [AngleW-1:0]         object_width;
    logic signed [MiddleW-1:0] object_middle_angle;
  } result_t;

endpackage

`default_nettype wire

FILE: sv/sed_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module sed_in_stage (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  output logic               ready_o,
  input  wire sed_pkg::item_t item_i,
  output logic               valid_o,
  input  wire logic          take_i,
  output sed_pkg::item_t     item_o
);
  import sed_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;

  assign ready_o = !valid_q || take_i;
  assign valid_d = (valid_i && ready_o) || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

FILE: sv/sed_core.sv
`timescale 1ns / 1ps
`default_nettype none

module sed_core (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       fire_i,
  input  wire sed_pkg::item_t             item_i,
  input  wire logic [sed_pkg::CountW-1:0] min_detections_i,
  output logic                            result_valid_o,
  output sed_pkg::result_t                result_o
);
  import sed_pkg::*;

  logic [DistW-1:0]   prev_q, prev_d;
  logic [DistW-1:0]   saved_q, saved_d;
  logic [AngleW-1:0]  start_q, start_d;
  logic [CountW-1:0]  count_q, count_d;
  logic               open_q, open_d;
  logic [NumberW-1:0] found_q, found_d;

  logic [ProdW-1:0]  cur10, entry9, exit11, saved9;
  logic              opens, stays, closes;
  logic [AngleW-1:0] width;
  logic [9:0]        middle_full;

  assign cur10  = ProdW'(item_i.ir_distance) * ProdW'(10);
  assign entry9 = ProdW'(prev_q) * ProdW'(9);
  assign exit11 = ProdW'(prev_q) * ProdW'(11);
  assign saved9 = ProdW'(saved_q) * ProdW'(9);

  assign width       = item_i.angle - start_q;
  assign middle_full = {2'b00, start_q} + {3'b000, width[AngleW-1:1]} - MiddleOffset;

  always_comb begin
    opens  = 1'b0;
    stays  = 1'b0;
    closes = 1'b0;
    if (!item_i.start_of_sweep && (prev_q != '0)) begin
      if (cur10 < entry9) begin
        opens = 1'b1;
      end else if (open_q && (cur10 < exit11) && (cur10 < saved9)) begin
        stays = 1'b1;
      end else if (open_q && (cur10 > exit11)) begin
        closes = 1'b1;
      end
    end
  end

  assign result_valid_o = closes && (count_q >= min_detections_i);

  always_comb begin
    prev_d  = item_i.ir_distance;
    saved_d = saved_q;
    start_d = start_q;
    count_d = count_q;
    open_d  = open_q;
    found_d = found_q;
    if (item_i.start_of_sweep) begin
      saved_d = '0;
      start_d = '0;
      count_d = '0;
      open_d  = 1'b0;
      found_d = '0;
    end else if (opens) begin
      start_d = item_i.angle;
      count_d = CountW'(1);
      open_d  = 1'b1;
      saved_d = prev_q;
    end else if (stays) begin
      if (count_q < CountMax) begin
        count_d = count_q + CountW'(1);
      end
    end else if (closes) begin
      open_d = 1'b0;
      if (result_valid_o && (found_q < NumberMax)) begin
        found_d = found_q + NumberW'(1);
      end
    end
  end

  always_comb begin
    result_o.object_number      = found_q;
    result_o.object_start_angle = start_q;
    result_o.object_width       = width;
    if ($signed(middle_full) > $signed(MiddleMax)) begin
      result_o.object_middle_angle = MiddleMax[MiddleW-1:0];
    end else begin
      result_o.object_middle_angle = middle_full[MiddleW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      saved_q <= '0;
      start_q <= '0;
      count_q <= '0;
      open_q  <= 1'b0;
      found_q <= '0;
    end else if (fire_i) begin
      prev_q  <= prev_d;
      saved_q <= saved_d;
      start_q <= start_d;
      count_q <= count_d;
      open_q  <= open_d;
      found_q <= found_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/sed_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module sed_out_stage (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  input  wire sed_pkg::result_t result_i,
  output logic                  free_o,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output sed_pkg::result_t      result_o
);
  import sed_pkg::*;

  logic    valid_q, valid_d;
  result_t result_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

`default_nettype wire

FILE: sv/sweep_object_edge_detector_top.sv
// Sweep object edge detector. One IR distance sample per servo angle enters on the slave
// stream and at most one object transaction leaves on the master stream. An item is accepted
// every cycle while the output side keeps up; each sample passes an input register, compare
// logic against the stored detector state, and an output register. Backpressure on the
// master side stalls the input register, and through it the slave side, only while a result
// is waiting. The minimum detection count is written on the configuration channel, which is
// always ready, and resets to 2.
`timescale 1ns / 1ps
`default_nettype none

module sweep_object_edge_detector_top (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [sed_pkg::CountW-1:0]   cfg_data_i,
  input  wire logic                         s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // Fields from bit 0: angle[7:0], ir_distance[18:8], zero fill[23:19].
  input  wire logic [sed_pkg::InDataW-1:0]  s_axis_tdata_i,
  // Fields from bit 0: start_of_sweep[0].
  input  wire logic                         s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  wire logic                         m_axis_tready_i,
  // Fields from bit 0: object_number[7:0], object_start_angle[15:8],
  // object_width[23:16], object_middle_angle[32:24], zero fill[39:33].
  output logic [sed_pkg::OutDataW-1:0]      m_axis_tdata_o
);
  import sed_pkg::*;

  logic [CountW-1:0] min_det_q;
  item_t             in_item, stage_item;
  logic              stage_valid, out_free, fire, res_valid;
  result_t           res, out_res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_det_q <= MinDetReset;
    end else if (cfg_valid_i) begin
      min_det_q <= cfg_data_i;
    end
  end

  assign in_item.start_of_sweep = s_axis_tuser_i;
  assign in_item.angle          = s_axis_tdata_i[AngleW-1:0];
  assign in_item.ir_distance    = s_axis_tdata_i[AngleW+DistW-1:AngleW];

  assign fire = stage_valid && out_free;

  sed_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .item_i  (in_item),
    .valid_o (stage_valid),
    .take_i  (fire),
    .item_o  (stage_item)
  );

  sed_core u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .fire_i           (fire),
    .item_i           (stage_item),
    .min_detections_i (min_det_q),
    .result_valid_o   (res_valid),
    .result_o         (res)
  );

  sed_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (fire && res_valid),
    .result_i (res),
    .free_o   (out_free),
    .valid_o  (m_axis_tvalid_o),
    .ready_i  (m_axis_tready_i),
    .result_o (out_res)
  );

  assign m_axis_tdata_o = {7'd0, out_res.object_middle_angle, out_res.object_width,
                           out_res.object_start_angle, out_res.object_number};

endmodule

`default_nettype wire

FILE: sv/sed_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module sed_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [39:0] m_axis_tdata_o
);

  logic [9:0] mid_calc;
  logic [8:0] mid_exp;

  assign mid_calc = {2'b00, m_axis_tdata_o[15:8]} + {3'b000, m_axis_tdata_o[23:17]} - 10'd2;
  assign mid_exp  = ($signed(mid_calc) > $signed(10'sd255)) ? 9'd255 : mid_calc[8:0];

  // A waiting result keeps its contents until the transaction completes.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // The input side only stalls while a result is held back by the consumer.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled without output backpressure");

  // The middle angle follows from start angle and width.
  a_middle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[32:24] == mid_exp)
    else $error("middle angle inconsistent with start and width");

  // The fill bits above the fields stay zero.
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[39:33] == 7'd0)
    else $error("output fill bits not zero");

endmodule

bind sweep_object_edge_detector_top sed_checker u_sed_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire
